[src/cps_pkg.sv]
// Shared constants and helpers for the cart-pole step unit.
`default_nettype none
package cps_pkg;
    localparam int WORD_BITS_DEF     = 32;
    localparam int FRACTION_BITS_DEF = 20;
    localparam int CFG_BITS          = 31;
    localparam int CFG_COUNT         = 8;
    localparam int CFG_IDX_BITS      = 3;
    localparam int FIELD_BITS        = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_FORCE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRAVITY = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PMASS   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TMASS   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HLEN    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAU     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_XLIM    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALIM    = 3'd7;

    localparam logic [CFG_BITS-1:0] RST_FORCE   = 31'd10485760;
    localparam logic [CFG_BITS-1:0] RST_GRAVITY = 31'd10276045;
    localparam logic [CFG_BITS-1:0] RST_PMASS   = 31'd104858;
    localparam logic [CFG_BITS-1:0] RST_TMASS   = 31'd1153434;
    localparam logic [CFG_BITS-1:0] RST_HLEN    = 31'd524288;
    localparam logic [CFG_BITS-1:0] RST_TAU     = 31'd20972;
    localparam logic [CFG_BITS-1:0] RST_XLIM    = 31'd2516582;
    localparam logic [CFG_BITS-1:0] RST_ALIM    = 31'd219613;

    localparam logic       ST_ACCEPTED   = 1'b0;
    localparam logic       ST_REJECTED   = 1'b1;

    localparam logic signed [63:0] PI_Q32   = 64'sd13493037704;
    localparam logic signed [63:0] GAIN_Q32 = 64'sd2608131496;

    // arctangent table, Q32; entries past the table are 2^(32-i)
    function automatic logic signed [63:0] atan_q32(input logic [4:0] i);
        case (i)
            5'd0:  atan_q32 = 64'sd3373259426;
            5'd1:  atan_q32 = 64'sd1991351318;
            5'd2:  atan_q32 = 64'sd1052175346;
            5'd3:  atan_q32 = 64'sd534100635;
            5'd4:  atan_q32 = 64'sd268086748;
            5'd5:  atan_q32 = 64'sd134174063;
            5'd6:  atan_q32 = 64'sd67103403;
            5'd7:  atan_q32 = 64'sd33553749;
            5'd8:  atan_q32 = 64'sd16777131;
            5'd9:  atan_q32 = 64'sd8388597;
            5'd10: atan_q32 = 64'sd4194303;
            5'd11: atan_q32 = 64'sd2097152;
            default: atan_q32 = 64'sd1 <<< (6'd32 - {1'b0, i});
        endcase
    endfunction
endpackage
`default_nettype wire

[src/cart_pole_physics_step_unit.sv]
// Cart-pole Euler step unit: sequencer, CORDIC, shared multiplier and divider.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one item: a load of the initial
//   state (i_load=1) or a step that pushes the cart left/right (i_action).
//   Output channel (o_valid/i_ready) returns one result beat per input beat:
//   the new state, reward, terminated and status (1 = rejected step).
//   Configuration: i_cfg_we/i_cfg_idx/i_cfg_data writes one of eight physics
//   registers; write only while the unit is idle.
// Sequence:
//   Loads and rejected steps: S_IDLE goes straight to S_OUT, which raises o_valid.
//   Accepted steps: angle reduction is a shift-and-subtract of shifted 2pi,
//   folding into +-pi/2, the 32 CORDIC iterations, then the micro-ops: the 15
//   multiplies share one multiplier (issue, S_MUL, S_MULW), the 7 adds run in
//   S_NEXT, and the four divisions share one radix-2 divider that retires
//   one quotient bit per cycle over WORD_BITS+FRACTION_BITS bits; then the
//   final angle add (S_ADD), the limit check (S_LIMIT) and S_OUT.
//   One item is in flight at a time; o_ready is low from accept until the
//   cycle after the result beat leaves the output register.
// Reset:
//   i_rst_n (synchronous, active low) clears the state, the flags and returns
//   registers to their defaults. A stalled receiver just holds the result beat
//   in the output register; the unit waits.
`default_nettype none
module cart_pole_physics_step_unit #(
    parameter int WORD_BITS     = cps_pkg::WORD_BITS_DEF,
    parameter int FRACTION_BITS = cps_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cps_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [cps_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_action,
    input  wire logic                          i_load,
    input  wire logic signed [cps_pkg::FIELD_BITS-1:0] i_init_position,
    input  wire logic signed [cps_pkg::FIELD_BITS-1:0] i_init_velocity,
    input  wire logic signed [cps_pkg::FIELD_BITS-1:0] i_init_angle,
    input  wire logic signed [cps_pkg::FIELD_BITS-1:0] i_init_angular_rate,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [cps_pkg::FIELD_BITS-1:0] o_position,
    output logic signed [cps_pkg::FIELD_BITS-1:0] o_velocity,
    output logic signed [cps_pkg::FIELD_BITS-1:0] o_angle,
    output logic signed [cps_pkg::FIELD_BITS-1:0] o_angular_rate,
    output logic                               o_reward,
    output logic                               o_terminated,
    output logic                               o_status
);
    import cps_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int SH = 32 - F;                 // may be negative
    localparam int XW = 2 * W + 2;              // wide product
    localparam int QB = W + F + 1;              // quotient bits needed
    localparam int NB = W + F;                  // dividend bits
    localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [63:0] PF =
        (SH > 0) ? ((PI_Q32 + (64'sd1 <<< ((SH > 0) ? SH - 1 : 0))) >>> ((SH > 0) ? SH : 0))
                 : PI_Q32;
    localparam logic signed [63:0] TP = 2 * PF;
    localparam logic signed [63:0] HP = PF / 2;
    localparam logic signed [W-1:0] FOUR3 = W'(((64'sd4 <<< F) + 64'sd1) / 3);
    localparam int CW = 64 + ((SH < 0) ? -SH : 0);  // CORDIC width
    // top shift of 2pi for the angle reduction; 2pi << RK exceeds any angle
    localparam int RK = (W - 1 - F > 0) ? W - 1 - F : 0;

    // one-hot sequencer
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RED   = 13'b0000000000010,
        S_CORD  = 13'b0000000000100,
        S_MUL   = 13'b0000000001000,
        S_MULW  = 13'b0000000010000,
        S_DIV   = 13'b0000000100000,
        S_DIVW  = 13'b0000001000000,
        S_ADD   = 13'b0000010000000,
        S_NEXT  = 13'b0000100000000,
        S_LIMIT = 13'b0001000000000,
        S_OUT   = 13'b0010000000000,
        S_FIN   = 13'b0100000000000,
        S_REDW  = 13'b1000000000000
    } t_state;

    // micro-op list, one entry per operation
    typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_ADD, OP_SUB} t_op;
    typedef struct packed {
        t_op        op;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] d;
    } t_uop;

    // scratch register file slots
    localparam logic [4:0] R_PM = 5'd0, R_TM = 5'd1, R_HL = 5'd2, R_G = 5'd3,
        R_TAU = 5'd4, R_F = 5'd5, R_SN = 5'd6, R_CS = 5'd7, R_X = 5'd8, R_V = 5'd9,
        R_A = 5'd10, R_R = 5'd11, R_PML = 5'd12, R_T1 = 5'd13, R_T2 = 5'd14,
        R_TEMP = 5'd15, R_NUM = 5'd16, R_FRAC = 5'd17, R_DEN = 5'd18, R_TACC = 5'd19,
        R_XACC = 5'd20, R_F43 = 5'd21, R_T3 = 5'd22;
    localparam int NOPS = 26;

    function automatic t_uop uop(input logic [4:0] k);
        case (k)
            5'd0:  uop = '{OP_MUL, R_PM,   R_HL,   R_PML};
            5'd1:  uop = '{OP_MUL, R_R,    R_R,    R_T1};
            5'd2:  uop = '{OP_MUL, R_PML,  R_T1,   R_T1};
            5'd3:  uop = '{OP_MUL, R_T1,   R_SN,   R_T1};
            5'd4:  uop = '{OP_ADD, R_F,    R_T1,   R_T1};
            5'd5:  uop = '{OP_DIV, R_T1,   R_TM,   R_TEMP};
            5'd6:  uop = '{OP_MUL, R_G,    R_SN,   R_T1};
            5'd7:  uop = '{OP_MUL, R_CS,   R_TEMP, R_T2};
            5'd8:  uop = '{OP_SUB, R_T1,   R_T2,   R_NUM};
            5'd9:  uop = '{OP_MUL, R_CS,   R_CS,   R_T1};
            5'd10: uop = '{OP_MUL, R_PM,   R_T1,   R_T1};
            5'd11: uop = '{OP_DIV, R_T1,   R_TM,   R_FRAC};
            5'd12: uop = '{OP_SUB, R_F43,  R_FRAC, R_T1};
            5'd13: uop = '{OP_MUL, R_HL,   R_T1,   R_DEN};
            5'd14: uop = '{OP_DIV, R_NUM,  R_DEN,  R_TACC};
            5'd15: uop = '{OP_MUL, R_PML,  R_TACC, R_T1};
            5'd16: uop = '{OP_MUL, R_T1,   R_CS,   R_T1};
            5'd17: uop = '{OP_DIV, R_T1,   R_TM,   R_T1};
            5'd18: uop = '{OP_SUB, R_TEMP, R_T1,   R_XACC};
            5'd19: uop = '{OP_MUL, R_TAU,  R_V,    R_T1};
            5'd20: uop = '{OP_MUL, R_TAU,  R_XACC, R_T2};
            5'd21: uop = '{OP_MUL, R_TAU,  R_R,    R_T3};
            5'd22: uop = '{OP_ADD, R_X,    R_T1,   R_X};
            5'd23: uop = '{OP_ADD, R_V,    R_T2,   R_V};
            5'd24: uop = '{OP_MUL, R_TAU,  R_TACC, R_T1};
            5'd25: uop = '{OP_ADD, R_R,    R_T1,   R_R};
            default: uop = '{OP_ADD, R_A, R_T3, R_A};
        endcase
    endfunction

    function automatic logic signed [W-1:0] satw(input logic signed [XW-1:0] v);
        if (v > XW'(MAXW))      satw = MAXW;
        else if (v < XW'(MINW)) satw = MINW;
        else                    satw = W'(v);
    endfunction

    function automatic logic signed [W-1:0] in_word(input logic signed [FIELD_BITS-1:0] v);
        in_word = satw(XW'(v));
    endfunction

    function automatic logic signed [W-1:0] reg_w(input logic [CFG_BITS-1:0] v);
        reg_w = satw(XW'({1'b0, v}));
    endfunction

    // configuration
    logic [CFG_BITS-1:0] r_cfg [CFG_COUNT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_FORCE]   <= RST_FORCE;
            r_cfg[REG_GRAVITY] <= RST_GRAVITY;
            r_cfg[REG_PMASS]   <= RST_PMASS;
            r_cfg[REG_TMASS]   <= RST_TMASS;
            r_cfg[REG_HLEN]    <= RST_HLEN;
            r_cfg[REG_TAU]     <= RST_TAU;
            r_cfg[REG_XLIM]    <= RST_XLIM;
            r_cfg[REG_ALIM]    <= RST_ALIM;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    t_state r_state;
    logic signed [W-1:0] r_rf [23];
    logic [4:0]  r_pc;
    logic [5:0]  r_cnt;
    logic        r_loaded, r_fallen, r_neg;
    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic signed [63:0]   r_red;
    logic signed [63:0]   r_tps;    // 2pi shifted, halves each reduction cycle
    logic                 r_rneg;   // angle was negative

    // shared multiplier: sign-magnitude, one registered pass
    logic [W-1:0]   r_ma, r_mb;
    logic           r_mneg;
    logic [2*W-1:0] r_mp;

    // shared divider: restoring, one bit per cycle
    logic [NB-1:0]  r_dn;
    logic [W-1:0]   r_dd;
    logic [W:0]     r_rem;
    logic [QB-1:0]  r_q;
    logic           r_dneg;
    logic [6:0]     r_dcnt;
    logic [2:0]     r_dz;     // {divisor zero, dividend negative, dividend zero}

    t_uop cur;
    assign cur = uop(r_pc);

    function automatic logic [W-1:0] magw(input logic signed [W-1:0] v);
        magw = v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic logic signed [W-1:0] from_mag(input logic [2*W-1:0] m,
                                                     input logic neg);
        logic signed [XW-1:0] s;
        s = XW'(m);
        from_mag = satw(neg ? -s : s);
    endfunction

    logic signed [XW-1:0] add_res;
    logic [W:0] rem_sh;
    logic [W:0] rem_try;
    always_comb begin
        if (cur.op == OP_SUB) add_res = XW'(r_rf[cur.a]) - XW'(r_rf[cur.b]);
        else                  add_res = XW'(r_rf[cur.a]) + XW'(r_rf[cur.b]);
        rem_sh  = {r_rem[W-1:0], r_dn[NB-1]};
        rem_try = rem_sh - {1'b0, r_dd};
    end

    // one compare-and-subtract step of the angle reduction
    logic signed [63:0] red_cut;
    always_comb begin
        red_cut = (r_red >= r_tps) ? r_red - r_tps : r_red;
    end

    logic signed [CW-1:0] dx, dy, atn;
    always_comb begin
        dx  = r_cy >>> r_cnt[4:0];
        dy  = r_cx >>> r_cnt[4:0];
        atn = CW'(atan_q32(r_cnt[4:0]));
    end

    logic signed [CW-1:0] cx_s, cy_s;
    always_comb begin
        cx_s = (SH > 0) ? (r_cx >>> ((SH > 0) ? SH : 0)) : r_cx;
        cy_s = (SH > 0) ? (r_cy >>> ((SH > 0) ? SH : 0)) : r_cy;
    end

    logic signed [W-1:0] xl, al;
    assign xl = reg_w(r_cfg[REG_XLIM]);
    assign al = reg_w(r_cfg[REG_ALIM]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_loaded <= 1'b0;
            r_fallen <= 1'b0;
            o_valid  <= 1'b0;
            for (int k = 0; k < 23; k++) r_rf[k] <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        o_status     <= ST_ACCEPTED;
                        o_reward     <= 1'b0;
                        o_terminated <= 1'b0;
                        if (i_load) begin
                            r_rf[R_X] <= in_word(i_init_position);
                            r_rf[R_V] <= in_word(i_init_velocity);
                            r_rf[R_A] <= in_word(i_init_angle);
                            r_rf[R_R] <= in_word(i_init_angular_rate);
                            r_loaded  <= 1'b1;
                            r_fallen  <= 1'b0;
                            r_state   <= S_OUT;
                        end else if (!r_loaded || r_fallen) begin
                            o_status     <= ST_REJECTED;
                            o_terminated <= r_fallen;
                            r_state      <= S_OUT;
                        end else begin
                            r_rf[R_PM]  <= reg_w(r_cfg[REG_PMASS]);
                            r_rf[R_TM]  <= reg_w(r_cfg[REG_TMASS]);
                            r_rf[R_HL]  <= reg_w(r_cfg[REG_HLEN]);
                            r_rf[R_G]   <= reg_w(r_cfg[REG_GRAVITY]);
                            r_rf[R_TAU] <= reg_w(r_cfg[REG_TAU]);
                            r_rf[R_F]   <= i_action ? reg_w(r_cfg[REG_FORCE])
                                                    : -reg_w(r_cfg[REG_FORCE]);
                            r_rf[R_F43] <= FOUR3;
                            // |theta| mod 2pi by shift and subtract
                            r_red   <= r_rf[R_A][W-1] ? -64'(r_rf[R_A]) : 64'(r_rf[R_A]);
                            r_rneg  <= r_rf[R_A][W-1];
                            r_tps   <= TP <<< RK;
                            r_cnt   <= 6'(RK);
                            r_neg   <= 1'b0;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    r_tps <= r_tps >>> 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        // floored remainder: negative angles map to 2pi - rem
                        r_red   <= (r_rneg && red_cut != 0) ? TP - red_cut : red_cut;
                        r_state <= S_REDW;
                    end else begin
                        r_red <= red_cut;
                    end
                end
                S_REDW: begin
                    if (r_red > PF) begin
                        r_red <= r_red - TP;
                    end else if (r_red > HP) begin
                        r_red <= r_red - PF;
                        r_neg <= 1'b1;
                    end else if (r_red < -HP) begin
                        r_red <= r_red + PF;
                        r_neg <= 1'b1;
                    end else begin
                        r_cx  <= CW'(GAIN_Q32);
                        r_cy  <= '0;
                        r_cz  <= (SH >= 0) ? (CW'(r_red) <<< ((SH > 0) ? SH : 0))
                                           : (CW'(r_red) >>> ((SH < 0) ? -SH : 0));
                        r_cnt <= '0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - dx; r_cy <= r_cy + dy; r_cz <= r_cz - atn;
                    end else begin
                        r_cx <= r_cx + dx; r_cy <= r_cy - dy; r_cz <= r_cz + atn;
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) r_state <= S_NEXT;
                    r_pc <= '0;
                end
                S_NEXT: begin
                    if (r_pc == 5'd0 && r_cnt == 6'd32) begin
                        r_rf[R_CS] <= r_neg ? -W'(cx_s) : W'(cx_s);
                        r_rf[R_SN] <= r_neg ? -W'(cy_s) : W'(cy_s);
                        r_cnt      <= '0;
                        r_state    <= S_NEXT;
                    end else if (r_pc == 5'(NOPS)) begin
                        r_state <= S_ADD;   // final angle update
                    end else begin
                        case (cur.op)
                            OP_MUL: begin
                                r_ma    <= magw(r_rf[cur.a]);
                                r_mb    <= magw(r_rf[cur.b]);
                                r_mneg  <= r_rf[cur.a][W-1] ^ r_rf[cur.b][W-1];
                                r_state <= S_MUL;
                            end
                            OP_DIV: begin
                                r_dn    <= {magw(r_rf[cur.a]), {F{1'b0}}};
                                r_dd    <= magw(r_rf[cur.b]);
                                r_dneg  <= r_rf[cur.a][W-1] ^ r_rf[cur.b][W-1];
                                r_dz    <= {r_rf[cur.b] == '0, r_rf[cur.a][W-1],
                                            r_rf[cur.a] == '0};
                                r_rem   <= '0;
                                r_q     <= '0;
                                r_dcnt  <= '0;
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_rf[cur.d] <= satw(add_res);
                                r_pc        <= r_pc + 5'd1;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_mp    <= r_ma * r_mb;
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    r_rf[cur.d] <= from_mag(r_mp >> F, r_mneg);
                    r_pc        <= r_pc + 5'd1;
                    r_state     <= S_NEXT;
                end
                S_DIV: begin
                    r_dn <= r_dn << 1;
                    if (!rem_try[W]) begin
                        r_rem <= rem_try;
                        r_q   <= {r_q[QB-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_q   <= {r_q[QB-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == 7'(NB - 1)) r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (r_dz[2]) begin
                        r_rf[cur.d] <= r_dz[0] ? '0 : (r_dz[1] ? MINW : MAXW);
                    end else begin
                        r_rf[cur.d] <= from_mag((2*W)'(r_q), r_dneg);
                    end
                    r_pc    <= r_pc + 5'd1;
                    r_state <= S_NEXT;
                end
                S_ADD: begin
                    r_rf[R_A] <= satw(XW'(r_rf[R_A]) + XW'(r_rf[R_T3]));
                    r_state   <= S_LIMIT;
                end
                S_LIMIT: begin
                    r_fallen <= (r_rf[R_X] < -xl) || (r_rf[R_X] > xl) ||
                                (r_rf[R_A] < -al) || (r_rf[R_A] > al);
                    o_terminated <= (r_rf[R_X] < -xl) || (r_rf[R_X] > xl) ||
                                    (r_rf[R_A] < -al) || (r_rf[R_A] > al);
                    o_reward <= !((r_rf[R_X] < -xl) || (r_rf[R_X] > xl) ||
                                  (r_rf[R_A] < -al) || (r_rf[R_A] > al));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_position     <= FIELD_BITS'(r_rf[R_X]);
                    o_velocity     <= FIELD_BITS'(r_rf[R_V]);
                    o_angle        <= FIELD_BITS'(r_rf[R_A]);
                    o_angular_rate <= FIELD_BITS'(r_rf[R_R]);
                    o_valid        <= 1'b1;
                    r_state        <= S_FIN;
                end
                S_FIN: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

[src/cps_checker.sv]
// Port-level checks for the cart-pole step unit, bound to the top level.
`default_nettype none
module cps_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_status,
    input wire logic o_reward,
    input wire logic o_terminated
);
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_rew: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_reward && o_terminated)) else $error("reward with termination");
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_reward) else $error("reward on rejected beat");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready held after input beat");
endmodule

bind cart_pole_physics_step_unit cps_checker u_cps_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_reward(o_reward), .o_terminated(o_terminated)
);
`default_nettype wire
